### src/fpt_pkg.sv
// package: shared types and constants for the fuzzy paired test tally
`timescale 1ns / 1ps
`default_nettype none
package fpt_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AccW = 33;
  localparam int unsigned ScoreW = 17;

  localparam logic [CfgIdxW-1:0] RegCenter1 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenter2 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHalf1 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHalf2 = 2'd3;

  localparam logic [ScoreW-1:0] ScoreOne = 17'h10000;
  localparam logic [ScoreW-1:0] ScoreHalf = 17'h08000;

  typedef struct packed {
    logic signed [15:0] pop1_reading1;
    logic signed [15:0] pop1_reading2;
    logic signed [15:0] pop2_reading1;
    logic signed [15:0] pop2_reading2;
    logic last_sample;
  } fpt_in_t;

  typedef struct packed {
    logic [AccW-1:0] p1_both_pos;
    logic [AccW-1:0] p1_only_second;
    logic [AccW-1:0] p1_only_first;
    logic [AccW-1:0] p1_both_neg;
    logic [AccW-1:0] p2_both_pos;
    logic [AccW-1:0] p2_only_second;
    logic [AccW-1:0] p2_only_first;
    logic [AccW-1:0] p2_both_neg;
  } fpt_out_t;

  // ramp job handed from front to back
  typedef struct packed {
    logic [3:0] div_mask;        // which readings need the divider
    logic [3:0][ScoreW-1:0] fixed_score;
    logic [3:0][15:0] num;       // d + hw, at most 2*hw
    logic [15:0] den1;
    logic [15:0] den2;
    logic last_sample;
  } fpt_job_t;

endpackage
`default_nettype wire

### src/fpt_front.sv
// front: classifies each reading against its ramp bounds
`timescale 1ns / 1ps
`default_nettype none
module fpt_front import fpt_pkg::*; (
  input  var fpt_in_t  item_i,
  input  var logic signed [15:0] center1_i,
  input  var logic signed [15:0] center2_i,
  input  var logic [14:0] half1_i,
  input  var logic [14:0] half2_i,
  output var fpt_job_t job_o
);

  logic signed [15:0] rd [4];
  logic signed [16:0] cen [4];
  logic signed [17:0] hw [4];
  logic signed [17:0] d [4];

  // per-reading classification
  always_comb begin
    rd[0] = item_i.pop1_reading1;
    rd[1] = item_i.pop1_reading2;
    rd[2] = item_i.pop2_reading1;
    rd[3] = item_i.pop2_reading2;
    job_o = '0;
    for (int k = 0; k < 4; k++) begin
      cen[k] = (k % 2 == 0) ? 17'(center1_i) : 17'(center2_i);
      hw[k] = (k % 2 == 0) ? 18'({3'b0, half1_i}) : 18'({3'b0, half2_i});
      d[k] = 18'(rd[k]) - 18'(cen[k]);
      job_o.num[k] = 16'(d[k] + hw[k]);
      if (d[k] < -hw[k]) begin
        job_o.fixed_score[k] = '0;
      end else if (d[k] > hw[k]) begin
        job_o.fixed_score[k] = ScoreOne;
      end else if (hw[k] == 18'sd0) begin
        job_o.fixed_score[k] = ScoreHalf;
      end else begin
        job_o.div_mask[k] = 1'b1;
      end
    end
    job_o.den1 = {half1_i, 1'b0};
    job_o.den2 = {half2_i, 1'b0};
    job_o.last_sample = item_i.last_sample;
  end

endmodule
`default_nettype wire

### src/fpt_back.sv
// back: serial ramp dividers, product terms and saturating tallies
`timescale 1ns / 1ps
`default_nettype none
module fpt_back import fpt_pkg::*; #(
  parameter logic [AccW-1:0] AccCap = '1
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic job_valid_i,
  output var logic job_ready_o,
  input  var fpt_job_t job_i,
  output var logic res_valid_o,
  input  var logic res_ready_i,
  output var fpt_out_t res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StMul = 2'd2;
  localparam logic [1:0] StAcc = 2'd3;

  logic [1:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] term_q, term_d;
  fpt_job_t job_q, job_d;
  logic [3:0][ScoreW-1:0] quo_q, quo_d;
  logic [3:0][16:0] rem_q, rem_d;
  logic [AccW-1:0] acc_q [8];
  logic [AccW-1:0] acc_d [8];
  logic [ScoreW-1:0] sc [4];
  logic [ScoreW-1:0] fa, fb;
  logic [33:0] prod_q, prod_d;
  logic [2:0] acc_idx;
  logic [AccW:0] sum;
  logic res_valid_q, res_valid_d;
  fpt_out_t res_q, res_d;
  logic [15:0] den [4];
  logic [16:0] trial;

  // score select: fixed or divider quotient
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sc[k] = job_q.div_mask[k] ? quo_q[k] : job_q.fixed_score[k];
      den[k] = (k % 2 == 0) ? job_q.den1 : job_q.den2;
    end
  end

  assign job_ready_o = (state_q == StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  // term operands: population from cnt, term 1 is a*(1-b), term 2 is (1-a)*b
  always_comb begin
    logic [1:0] pa;
    pa = cnt_q[0] ? 2'd2 : 2'd0;
    fb = term_q[0] ? ScoreOne - sc[{cnt_q[0], 1'b1}] : sc[{cnt_q[0], 1'b1}];
    fa = term_q[1] ? ScoreOne - sc[pa] : sc[pa];
    acc_idx = {cnt_q[0], term_q[0], term_q[1]};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    term_d = term_q;
    job_d = job_q;
    quo_d = quo_q;
    rem_d = rem_q;
    prod_d = prod_q;
    res_valid_d = res_valid_q;
    res_d = res_q;
    trial = '0;
    sum = '0;
    for (int k = 0; k < 8; k++) acc_d[k] = acc_q[k];
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i && job_ready_o) begin
          job_d = job_i;
          cnt_d = '0;
          quo_d = '0;
          for (int k = 0; k < 4; k++) rem_d[k] = 17'(job_i.num[k]);
          state_d = (job_i.div_mask != '0) ? StDiv : StMul;
          if (job_i.div_mask == '0) cnt_d = '0;
          term_d = '0;
        end
      end
      StDiv: begin
        // one quotient bit per cycle per reading: (num<<16)/den
        for (int k = 0; k < 4; k++) begin
          trial = rem_q[k] - 17'(den[k]);
          if (rem_q[k] >= 17'(den[k])) begin
            quo_d[k] = {quo_q[k][ScoreW-2:0], 1'b1};
            rem_d[k] = {trial[15:0], 1'b0};
          end else begin
            quo_d[k] = {quo_q[k][ScoreW-2:0], 1'b0};
            rem_d[k] = {rem_q[k][15:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = StMul;
          cnt_d = '0;
          term_d = '0;
        end
      end
      StMul: begin
        prod_d = 34'(fa) * 34'(fb);
        state_d = StAcc;
      end
      default: begin
        // closing step of a last column waits while the previous result is unpopped
        if (!(term_q == 2'd3 && cnt_q[0] && job_q.last_sample && res_valid_q &&
              !res_ready_i)) begin
          sum = {1'b0, acc_q[acc_idx]} + 34'(prod_q[33:16]);
          acc_d[acc_idx] = (sum > 34'(AccCap)) ? AccCap : sum[AccW-1:0];
          term_d = term_q + 2'd1;
          state_d = StMul;
          if (term_q == 2'd3) begin
            cnt_d = cnt_q + 5'd1;
            if (cnt_q[0]) begin
              state_d = StIdle;
              if (job_q.last_sample) begin
                res_valid_d = 1'b1;
                res_d = {acc_d[0], acc_d[1], acc_d[2], acc_d[3],
                         acc_d[4], acc_d[5], acc_d[6], acc_d[7]};
                for (int k = 0; k < 8; k++) acc_d[k] = '0;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_valid_q <= 1'b0;
      cnt_q <= '0;
      term_q <= '0;
      for (int k = 0; k < 8; k++) acc_q[k] <= '0;
    end else begin
      state_q <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q <= cnt_d;
      term_q <= term_d;
      for (int k = 0; k < 8; k++) acc_q[k] <= acc_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    prod_q <= prod_d;
    res_q <= res_d;
  end

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |=> res_valid_q && $stable(res_q))
    else $error("result lost");
  // jobs only taken from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |-> state_q == StIdle)
    else $error("job taken while busy");
  // divider runs 17 steps at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> cnt_q <= 5'd16)
    else $error("divider overrun");

endmodule
`default_nettype wire

### src/fuzzy_paired_test_tally_core.sv
// top level: config registers, front classifier, job queue and back end
`timescale 1ns / 1ps
`default_nettype none
// When any reading lies inside a ramp, the back end takes the job, runs the four parallel
// serial dividers over the full quotient width, then does eight multiply and accumulate
// steps; otherwise it goes straight from the job to those steps. The serial dividers and
// the single multiplier set the pace. A two-entry job queue lets the front accept items
// while the back end works, and a result register lets the next column start while a
// result waits; only the closing step of a last column stalls until that result is popped.
module fuzzy_paired_test_tally_core import fpt_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic push,
  output var logic full,
  input  var fpt_in_t item_i,
  output var logic empty,
  input  var logic pop,
  output var fpt_out_t result_o,
  input  var logic cfg_we_i,
  input  var logic [CfgIdxW-1:0] cfg_idx_i,
  input  var logic [CfgDataW-1:0] cfg_data_i
);

  localparam longint unsigned CapRaw = longint'(MAX_SAMPLES) << 16;
  localparam logic [AccW-1:0] AccCap =
    (CapRaw > 64'h1FFFFFFFF) ? '1 : AccW'(CapRaw);

  logic signed [15:0] center1_q, center2_q;
  logic [14:0] half1_q, half2_q;
  fpt_job_t job;
  fpt_job_t fifo_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic back_ready, res_valid;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center1_q <= '0;
      center2_q <= '0;
      half1_q <= '0;
      half2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCenter1: center1_q <= cfg_data_i;
        RegCenter2: center2_q <= cfg_data_i;
        RegHalf1: half1_q <= cfg_data_i[14:0];
        default: half2_q <= cfg_data_i[14:0];
      endcase
    end
  end

  fpt_front u_front (
    .item_i(item_i), .center1_i(center1_q), .center2_i(center2_q),
    .half1_i(half1_q), .half2_i(half2_q), .job_o(job)
  );

  // job queue between front and back
  logic do_push, do_pop;
  assign full = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop = (cnt_q != 2'd0) && back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_q] <= job;
  end

  fpt_back #(.AccCap(AccCap)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .job_valid_i(cnt_q != 2'd0), .job_ready_o(back_ready), .job_i(fifo_q[rd_q]),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(result_o)
  );

  assign empty = !res_valid;

  // queue count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  // push into a full queue never changes the count upward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !do_pop |=> cnt_q == 2'd2)
    else $error("queue count slipped");
  // pointers agree with count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> wr_q == rd_q)
    else $error("queue pointers out of step");

endmodule
`default_nettype wire
